### src/pff_pkg.sv
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types, codes and helpers of the Pareto frontier filter.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam int OBJ_W   = 32;  // one objective value
    localparam int TAG_W   = 16;  // solution tag
    localparam int SLOT_W  = 6;   // slot index field
    localparam int CNT_W   = 7;   // reported counts
    localparam int MAX_OBJ = 4;   // objective ports on the interface

    typedef logic signed [OBJ_W-1:0] t_obj;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_DOMINATED = 2'd1,
        ST_FULL      = 2'd2,
        ST_DONE      = 2'd3
    } t_status;

    // Add two objectives and clamp to the signed 32-bit range.
    function automatic t_obj sat_add(input t_obj a, input t_obj b);
        logic signed [OBJ_W:0] sum;
        t_obj                  res;
        sum = {a[OBJ_W-1], a} + {b[OBJ_W-1], b};
        if (sum[OBJ_W] != sum[OBJ_W-1]) begin
            res = sum[OBJ_W] ? {1'b1, {(OBJ_W-1){1'b0}}} : {1'b0, {(OBJ_W-1){1'b1}}};
        end else begin
            res = sum[OBJ_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/pff_store.sv
// ----------------------------------------------------------------------------
// pff_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pff_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 113
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/pff_dom.sv
// ----------------------------------------------------------------------------
// pff_dom
// Weak dominance test: every objective of A is at least that of B.
// ----------------------------------------------------------------------------
module pff_dom #(
    parameter int NUM_OBJECTIVES = 3
) (
    input  logic [NUM_OBJECTIVES*pff_pkg::OBJ_W-1:0] i_a,
    input  logic [NUM_OBJECTIVES*pff_pkg::OBJ_W-1:0] i_b,
    output logic                                     o_ge
);

    always_comb begin
        o_ge = 1'b1;
        for (int k = 0; k < NUM_OBJECTIVES; k++) begin
            if ($signed(i_a[k*pff_pkg::OBJ_W +: pff_pkg::OBJ_W]) <
                $signed(i_b[k*pff_pkg::OBJ_W +: pff_pkg::OBJ_W])) begin
                o_ge = 1'b0;
            end
        end
    end

endmodule

### src/pareto_frontier_filter_unit.sv
// ----------------------------------------------------------------------------
// pareto_frontier_filter_unit
// Table of mutually non-dominated objective vectors (larger is better).
// ----------------------------------------------------------------------------
// One transaction is processed at a time. Every slot lives in a single entry
// memory row {valid, tag, objectives}, read through a registered port, and
// every pass walks that memory one row per cycle. After reset a clearing pass
// writes every valid bit to zero; the input stays not ready during it. An
// insert reads every slot to find whether the candidate is dominated, how
// many slots it beats and the lowest slot that will be free. A rejected
// insert ends after that scan; a stored one writes its row, and when it
// removes entries a second walk first clears the beaten rows by
// read-modify-write. A clear opcode repeats the clearing pass; a read
// fetches one row and a no-op goes straight to its result. The result sits
// in an output register, so the next transaction is accepted while it still
// waits to be taken.
// ----------------------------------------------------------------------------
module pareto_frontier_filter_unit #(
    parameter int CAPACITY       = 64,
    parameter int NUM_OBJECTIVES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_objective_0,
    input  logic [31:0] i_objective_1,
    input  logic [31:0] i_objective_2,
    input  logic [31:0] i_objective_3,
    input  logic [31:0] i_offset_0,
    input  logic [31:0] i_offset_1,
    input  logic [31:0] i_offset_2,
    input  logic [31:0] i_offset_3,
    input  logic [15:0] i_solution_tag,
    input  logic [5:0]  i_slot_index,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_removed_count,
    output logic [6:0]  o_entry_count,
    output logic        o_slot_valid,
    output logic [31:0] o_read_objective_0,
    output logic [31:0] o_read_objective_1,
    output logic [31:0] o_read_objective_2,
    output logic [31:0] o_read_objective_3,
    output logic [15:0] o_read_tag
);

    localparam int OW    = pff_pkg::OBJ_W;
    localparam int AW    = $clog2(CAPACITY);
    localparam int LW    = $clog2(CAPACITY + 1);
    localparam int VW    = NUM_OBJECTIVES * OW;           // objective part of a row
    localparam int PW    = VW + pff_pkg::TAG_W;           // row without valid bit
    localparam int ROW_W = PW + 1;
    localparam int XW    = (AW > pff_pkg::SLOT_W) ? AW : pff_pkg::SLOT_W;
    localparam int PADW  = pff_pkg::MAX_OBJ * OW;

    typedef enum logic [7:0] {
        S_SWEEP  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_PRUNE  = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // control registers
    t_state           r_state,     n_state;
    logic [AW:0]      r_idx,       n_idx;
    logic             r_rd_pend,   n_rd_pend;
    logic [AW-1:0]    r_rd_slot,   n_rd_slot;
    logic [LW-1:0]    r_live,      n_live;
    logic             r_sweep_op,  n_sweep_op;
    logic             r_out_valid, n_out_valid;
    // working payload
    logic             r_dominated, n_dominated;
    logic [LW-1:0]    r_beaten,    n_beaten;
    logic             r_free_found, n_free_found;
    logic [AW-1:0]    r_free_slot, n_free_slot;
    logic [VW-1:0]    r_cand,      n_cand;
    logic [pff_pkg::TAG_W-1:0] r_tag, n_tag;
    logic             r_read_ok,   n_read_ok;
    pff_pkg::t_status r_res_status, n_res_status;
    logic [LW-1:0]    r_res_removed, n_res_removed;
    logic             r_res_slot_valid, n_res_slot_valid;
    logic [PW-1:0]    r_res_row,   n_res_row;
    // output registers
    pff_pkg::t_status r_o_status,  n_o_status;
    logic [6:0]       r_o_removed, n_o_removed;
    logic [6:0]       r_o_entry,   n_o_entry;
    logic             r_o_slot_valid, n_o_slot_valid;
    logic [PADW-1:0]  r_o_objs,    n_o_objs;
    logic [15:0]      r_o_tag,     n_o_tag;

    // memory port
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] mem_q;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [ROW_W-1:0] mem_wr_data;

    logic             row_valid;
    logic [VW-1:0]    row_obj;
    logic             stored_ge;   // stored entry at least as good as candidate
    logic             cand_ge;     // candidate at least as good as stored entry
    logic             in_accept;
    logic             issue;
    logic             last_eval;
    logic [XW-1:0]    slot_ext;
    logic             slot_in_range;
    pff_pkg::t_obj    in_obj [pff_pkg::MAX_OBJ];
    pff_pkg::t_obj    in_off [pff_pkg::MAX_OBJ];
    logic [PADW-1:0]  res_objs_pad;

    pff_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_q),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign row_valid = mem_q[ROW_W-1];
    assign row_obj   = mem_q[VW-1:0];

    pff_dom #(.NUM_OBJECTIVES(NUM_OBJECTIVES)) u_dom_stored (
        .i_a  (row_obj),
        .i_b  (r_cand),
        .o_ge (stored_ge)
    );

    pff_dom #(.NUM_OBJECTIVES(NUM_OBJECTIVES)) u_dom_cand (
        .i_a  (r_cand),
        .i_b  (row_obj),
        .o_ge (cand_ge)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    assign in_obj[0] = i_objective_0;
    assign in_obj[1] = i_objective_1;
    assign in_obj[2] = i_objective_2;
    assign in_obj[3] = i_objective_3;
    assign in_off[0] = i_offset_0;
    assign in_off[1] = i_offset_1;
    assign in_off[2] = i_offset_2;
    assign in_off[3] = i_offset_3;

    assign slot_ext      = XW'(i_slot_index);
    assign slot_in_range = (32'(i_slot_index) < 32'(CAPACITY));

    // Walk control shared by the scan and prune passes.
    assign issue     = (r_idx < (AW+1)'(CAPACITY));
    assign last_eval = r_rd_pend && (r_rd_slot == AW'(CAPACITY - 1));

    assign res_objs_pad = PADW'(r_res_row[VW-1:0]);

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_rd_pend        = 1'b0;
        n_rd_slot        = r_idx[AW-1:0];
        n_live           = r_live;
        n_sweep_op       = r_sweep_op;
        n_out_valid      = r_out_valid;
        n_dominated      = r_dominated;
        n_beaten         = r_beaten;
        n_free_found     = r_free_found;
        n_free_slot      = r_free_slot;
        n_cand           = r_cand;
        n_tag            = r_tag;
        n_read_ok        = r_read_ok;
        n_res_status     = r_res_status;
        n_res_removed    = r_res_removed;
        n_res_slot_valid = r_res_slot_valid;
        n_res_row        = r_res_row;
        n_o_status       = r_o_status;
        n_o_removed      = r_o_removed;
        n_o_entry        = r_o_entry;
        n_o_slot_valid   = r_o_slot_valid;
        n_o_objs         = r_o_objs;
        n_o_tag          = r_o_tag;

        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx[AW-1:0];
        mem_wr_data = '0;

        // drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_SWEEP: begin
                // clear one valid bit per cycle
                mem_wr_en = 1'b1;
                n_idx     = r_idx + (AW+1)'(1);
                if (r_idx == (AW+1)'(CAPACITY - 1)) begin
                    n_idx            = '0;
                    n_live           = '0;
                    n_res_status     = pff_pkg::ST_DONE;
                    n_res_removed    = '0;
                    n_res_slot_valid = 1'b0;
                    n_state          = r_sweep_op ? S_DONE : S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_accept) begin
                    n_res_removed    = '0;
                    n_res_slot_valid = 1'b0;
                    n_res_status     = pff_pkg::ST_DONE;
                    case (pff_pkg::t_opcode'(i_opcode))
                        pff_pkg::OP_INSERT: begin
                            for (int k = 0; k < NUM_OBJECTIVES; k++) begin
                                n_cand[k*OW +: OW] = pff_pkg::sat_add(in_obj[k], in_off[k]);
                            end
                            n_tag        = i_solution_tag;
                            n_idx        = '0;
                            n_dominated  = 1'b0;
                            n_beaten     = '0;
                            n_free_found = 1'b0;
                            n_state      = S_SCAN;
                        end
                        pff_pkg::OP_CLEAR: begin
                            n_idx      = '0;
                            n_sweep_op = 1'b1;
                            n_state    = S_SWEEP;
                        end
                        pff_pkg::OP_READ: begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = slot_ext[AW-1:0];
                            n_read_ok   = slot_in_range;
                            n_state     = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one read per cycle, evaluate the row returned
                if (issue) begin
                    mem_rd_en = 1'b1;
                    n_idx     = r_idx + (AW+1)'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    if (row_valid && stored_ge) begin
                        n_dominated = 1'b1;
                    end
                    if (row_valid && cand_ge) begin
                        n_beaten = r_beaten + LW'(1);
                    end
                    // lowest slot that is free once beaten rows are gone
                    if (!r_free_found && (!row_valid || cand_ge)) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_rd_slot;
                    end
                end
                if (last_eval) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_idx = '0;
                if (r_dominated) begin
                    n_res_status = pff_pkg::ST_DOMINATED;
                    n_state      = S_DONE;
                end else if ((r_live - r_beaten) >= LW'(CAPACITY)) begin
                    n_res_status = pff_pkg::ST_FULL;
                    n_state      = S_DONE;
                end else if (r_beaten != '0) begin
                    n_state = S_PRUNE;
                end else begin
                    n_state = S_WRITE;
                end
            end

            S_PRUNE: begin
                // read slot i+1 while writing back slot i
                if (issue) begin
                    mem_rd_en = 1'b1;
                    n_idx     = r_idx + (AW+1)'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend && row_valid && cand_ge) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_rd_slot;
                    mem_wr_data = {1'b0, mem_q[PW-1:0]};
                end
                if (last_eval) begin
                    n_state = S_WRITE;
                end
            end

            S_WRITE: begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = r_free_slot;
                mem_wr_data   = {1'b1, r_tag, r_cand};
                n_live        = r_live - r_beaten + LW'(1);
                n_res_status  = pff_pkg::ST_ADDED;
                n_res_removed = r_beaten;
                n_state       = S_DONE;
            end

            S_READ: begin
                n_res_slot_valid = r_read_ok && row_valid;
                n_res_row        = mem_q[PW-1:0];
                n_state          = S_DONE;
            end

            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_o_status     = r_res_status;
                    n_o_removed    = 7'(r_res_removed);
                    n_o_entry      = 7'(r_live);
                    n_o_slot_valid = r_res_slot_valid;
                    n_o_objs       = r_res_slot_valid ? res_objs_pad : '0;
                    n_o_tag        = r_res_slot_valid ? r_res_row[PW-1:VW] : '0;
                    n_sweep_op     = 1'b0;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_live      <= '0;
            r_sweep_op  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_pend   <= n_rd_pend;
            r_live      <= n_live;
            r_sweep_op  <= n_sweep_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot        <= n_rd_slot;
        r_dominated      <= n_dominated;
        r_beaten         <= n_beaten;
        r_free_found     <= n_free_found;
        r_free_slot      <= n_free_slot;
        r_cand           <= n_cand;
        r_tag            <= n_tag;
        r_read_ok        <= n_read_ok;
        r_res_status     <= n_res_status;
        r_res_removed    <= n_res_removed;
        r_res_slot_valid <= n_res_slot_valid;
        r_res_row        <= n_res_row;
        r_o_status       <= n_o_status;
        r_o_removed      <= n_o_removed;
        r_o_entry        <= n_o_entry;
        r_o_slot_valid   <= n_o_slot_valid;
        r_o_objs         <= n_o_objs;
        r_o_tag          <= n_o_tag;
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_removed_count    = r_o_removed;
    assign o_entry_count      = r_o_entry;
    assign o_slot_valid       = r_o_slot_valid;
    assign o_read_objective_0 = r_o_objs[0*OW +: OW];
    assign o_read_objective_1 = r_o_objs[1*OW +: OW];
    assign o_read_objective_2 = r_o_objs[2*OW +: OW];
    assign o_read_objective_3 = r_o_objs[3*OW +: OW];
    assign o_read_tag         = r_o_tag;

endmodule

### src/pff_chk.sv
// ----------------------------------------------------------------------------
// pff_chk
// Port-level checks of the Pareto frontier filter, bound to the top level.
// ----------------------------------------------------------------------------
module pff_chk #(
    parameter int CAPACITY       = 64,
    parameter int NUM_OBJECTIVES = 3
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [6:0]  o_removed_count,
    input logic [6:0]  o_entry_count,
    input logic        o_slot_valid,
    input logic [31:0] o_read_objective_3
);

    // no result may be left pending across a reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a full rejection removes nothing and reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == pff_pkg::ST_FULL) |->
            (o_removed_count == '0) && (o_entry_count == 7'(CAPACITY)))
        else $error("full rejection with inconsistent counts");

    // only a read reports a valid slot, and it removes nothing
    a_read_only_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_valid |->
            (o_status == pff_pkg::ST_DONE) && (o_removed_count == '0))
        else $error("slot data on a non-read result");

    // the fourth objective reads as zero when fewer objectives are configured
    a_unused_objective: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (NUM_OBJECTIVES < pff_pkg::MAX_OBJ) |->
            (o_read_objective_3 == '0))
        else $error("unused objective not zero");

    // a stalled result holds its valid, status and entry count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("stalled result changed");

endmodule

bind pareto_frontier_filter_unit pff_chk #(
    .CAPACITY       (CAPACITY),
    .NUM_OBJECTIVES (NUM_OBJECTIVES)
) u_pff_chk (.*);
